[rtl/core/ncc_pkg.sv]
// ----------------------------------------------------------------------------
// ncc_pkg: shared types and constants of the nearest centroid classifier
// Field widths, the packed feature vector, queue status and register indexes.
// ----------------------------------------------------------------------------
package ncc_pkg;

    localparam int CODE_W       = 12;   // raw sensor code
    localparam int FRAC_W       = 12;   // Q0.12 feature and centroid coordinate
    localparam int NUM_FIELDS   = 5;    // sensor codes per sample
    localparam int MAX_CLUSTERS = 3;
    localparam int CFG_W        = 60;   // widest configuration register
    localparam int CFG_IDX_W    = 3;
    localparam int MAP_W        = 6;
    localparam int CLASS_W      = 2;
    localparam int IDX_W        = 2;
    localparam int SQ_W         = 2 * FRAC_W;
    localparam int DIST_W       = 27;
    localparam int BITS_PER_STEP = 2;   // quotient bits resolved per cycle
    localparam int DIV_STEPS    = FRAC_W / BITS_PER_STEP;
    localparam int QUEUE_DEPTH  = 2;

    typedef logic [CODE_W-1:0]                  t_code;
    typedef logic [FRAC_W-1:0]                  t_frac;
    typedef logic [NUM_FIELDS-1:0][FRAC_W-1:0]  t_feat_vec;
    typedef logic [CFG_W-1:0]                   t_word;
    typedef logic [MAP_W-1:0]                   t_map;
    typedef logic [DIST_W-1:0]                  t_dist;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWS  = 3'd0,
        CFG_HIGHS = 3'd1,
        CFG_CEN0  = 3'd2,
        CFG_CEN1  = 3'd3,
        CFG_CEN2  = 3'd4,
        CFG_MAP   = 3'd5
    } t_cfg_idx;

endpackage

[rtl/core/ncc_norm.sv]
// ----------------------------------------------------------------------------
// ncc_norm: front end, min-max normalisation of the sensor codes
// One restoring divider per feature, two quotient bits per cycle; the finished
// feature vector is offered to the queue and held until it is taken.
// ----------------------------------------------------------------------------
module ncc_norm #(
    parameter int FEATURES = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ncc_pkg::t_feat_vec i_codes,
    input  ncc_pkg::t_word    i_lows,
    input  ncc_pkg::t_word    i_highs,
    input  logic              i_push_ok,
    output logic              o_busy,
    output logic              o_valid,
    output ncc_pkg::t_feat_vec o_feat
);
    import ncc_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic             r_run;
    logic [CNT_W-1:0] r_cnt;
    logic             step;
    logic             done;

    // Sequence the divide steps, then hold the result until the queue has room
    assign step    = r_run && (r_cnt != CNT_W'(DIV_STEPS));
    assign done    = r_run && (r_cnt == CNT_W'(DIV_STEPS));
    assign o_valid = done;
    assign o_busy  = r_run && !(done && i_push_ok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= '0;
        end else if (done && i_push_ok) begin
            r_run <= 1'b0;
        end else if (step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // One divider lane per feature
    for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_lane
        if (k < FEATURES) begin : g_on
            t_code       low;
            t_code       high;
            t_code       diff;
            t_code       range_w;
            logic        clr;
            logic        sat;
            logic [FRAC_W:0] r_rem;
            t_frac       r_div;
            t_frac       r_quo;
            logic        r_clr;
            logic        r_sat;
            logic [FRAC_W:0] n_rem;
            t_frac       n_quo;

            assign low     = i_lows[k*CODE_W +: CODE_W];
            assign high    = i_highs[k*CODE_W +: CODE_W];
            assign diff    = i_codes[k] - low;
            assign range_w = high - low;
            // Empty range or code at or below the floor gives zero; at or above the ceiling, saturate
            assign clr     = (high <= low) || (i_codes[k] <= low);
            assign sat     = !clr && (diff >= range_w);

            // Two restoring steps per cycle
            always_comb begin
                logic [FRAC_W:0] rem;
                logic [FRAC_W:0] sh;
                t_frac           quo;
                rem = r_rem;
                quo = r_quo;
                for (int i = 0; i < BITS_PER_STEP; i++) begin
                    sh = {rem[FRAC_W-1:0], 1'b0};
                    if (sh >= {1'b0, r_div}) begin
                        rem = sh - {1'b0, r_div};
                        quo = {quo[FRAC_W-2:0], 1'b1};
                    end else begin
                        rem = sh;
                        quo = {quo[FRAC_W-2:0], 1'b0};
                    end
                end
                n_rem = rem;
                n_quo = quo;
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= {1'b0, diff};
                    r_div <= range_w;
                    r_quo <= '0;
                    r_clr <= clr;
                    r_sat <= sat;
                end else if (step) begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                end
            end

            assign o_feat[k] = r_clr ? '0 : (r_sat ? '1 : r_quo);
        end else begin : g_off
            assign o_feat[k] = '0;
        end
    end

endmodule

[rtl/core/ncc_queue.sv]
// ----------------------------------------------------------------------------
// ncc_queue: short queue of normalised feature vectors
// Decouples the divider front end from the distance back end.
// ----------------------------------------------------------------------------
module ncc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ncc_pkg::t_feat_vec i_data,
    input  logic               i_pop,
    output ncc_pkg::t_feat_vec o_data,
    output ncc_pkg::t_q_status o_status
);
    import ncc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_feat_vec        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;

    assign o_data          = r_mem[r_rp];
    assign o_status.full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty  = (r_count == '0);

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/core/ncc_dist.sv]
// ----------------------------------------------------------------------------
// ncc_dist: back end, squared distance and nearest centroid search
// One cluster per cycle: squares in a first stage, sum and compare in a
// second, and a registered result strobe after the last cluster.
// ----------------------------------------------------------------------------
module ncc_dist #(
    parameter int FEATURES = 5,
    parameter int CLUSTERS = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ncc_pkg::t_q_status                  i_q_status,
    input  ncc_pkg::t_feat_vec                  i_feat,
    input  ncc_pkg::t_word [CLUSTERS-1:0]       i_cen,
    input  ncc_pkg::t_map                       i_map,
    output logic                                o_pop,
    output logic                                o_done,
    output logic [ncc_pkg::IDX_W-1:0]           o_cluster_index,
    output logic [ncc_pkg::CLASS_W-1:0]         o_health_class,
    output ncc_pkg::t_dist                      o_nearest_distance
);
    import ncc_pkg::*;

    logic             r_busy;
    logic [IDX_W-1:0] r_c;
    t_feat_vec        r_feat;
    logic             r_s1_valid;
    logic [IDX_W-1:0] r_s1_c;
    logic             r_s1_last;
    logic [SQ_W-1:0]  r_sq [FEATURES];
    t_dist            r_best;
    logic [IDX_W-1:0] r_bidx;
    logic             r_done;
    logic [IDX_W-1:0] r_out_idx;
    logic [CLASS_W-1:0] r_out_class;
    t_dist            r_out_dist;

    t_word            cen_sel;
    logic [SQ_W-1:0]  sq [FEATURES];
    logic             last_issue;
    t_dist            dist_sum;
    t_dist            n_best;
    logic [IDX_W-1:0] n_bidx;
    t_map             map_sh;

    assign o_pop      = !r_busy && !i_q_status.empty;
    assign last_issue = (r_c == IDX_W'(CLUSTERS - 1));

    // Select the centroid of the cluster being issued
    always_comb begin
        cen_sel = '0;
        for (int i = 0; i < CLUSTERS; i++) begin
            if (r_c == IDX_W'(i)) begin
                cen_sel = i_cen[i];
            end
        end
    end

    // Squared coordinate differences, one multiplier per feature
    for (genvar k = 0; k < FEATURES; k++) begin : g_sq
        t_frac cc;
        t_frac d;
        assign cc    = cen_sel[k*FRAC_W +: FRAC_W];
        assign d     = (r_feat[k] >= cc) ? r_feat[k] - cc : cc - r_feat[k];
        assign sq[k] = SQ_W'(d) * SQ_W'(d);
    end

    // Sum the squares and keep the strictly smaller distance
    always_comb begin
        dist_sum = '0;
        for (int k = 0; k < FEATURES; k++) begin
            dist_sum = dist_sum + DIST_W'(r_sq[k]);
        end
        if ((r_s1_c == IDX_W'(0)) || (dist_sum < r_best)) begin
            n_best = dist_sum;
            n_bidx = r_s1_c;
        end else begin
            n_best = r_best;
            n_bidx = r_bidx;
        end
        map_sh = i_map >> {n_bidx, 1'b0};
    end

    // Control: take a vector, issue each cluster, flag the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_c        <= '0;
            r_s1_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_s1_valid <= r_busy;
            r_done     <= r_s1_valid && r_s1_last;
            if (o_pop) begin
                r_busy <= 1'b1;
                r_c    <= '0;
            end else if (r_busy) begin
                if (last_issue) begin
                    r_busy <= 1'b0;
                end
                r_c <= r_c + IDX_W'(1);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_feat <= i_feat;
        end
        if (r_busy) begin
            for (int k = 0; k < FEATURES; k++) begin
                r_sq[k] <= sq[k];
            end
            r_s1_c    <= r_c;
            r_s1_last <= last_issue;
        end
        if (r_s1_valid) begin
            r_best <= n_best;
            r_bidx <= n_bidx;
        end
        if (r_s1_valid && r_s1_last) begin
            r_out_idx   <= n_bidx;
            r_out_class <= map_sh[CLASS_W-1:0];
            r_out_dist  <= n_best;
        end
    end

    assign o_done             = r_done;
    assign o_cluster_index    = r_out_idx;
    assign o_health_class     = r_out_class;
    assign o_nearest_distance = r_out_dist;

endmodule

[rtl/core/nearest_centroid_classifier.sv]
// ----------------------------------------------------------------------------
// nearest_centroid_classifier: k-means nearest centroid classification
// Normalises five sensor codes and returns the nearest of CLUSTERS centroids.
// ----------------------------------------------------------------------------
// Usage
//   Input: a sample is taken at a rising edge with start high and busy low.
//   Output: o_done is high for one cycle with o_cluster_index, o_health_class
//   and o_nearest_distance; the receiver cannot stall, so no back-pressure.
//   Configuration: write i_cfg_data to register i_cfg_index on i_cfg_we, only
//   while no sample is in flight. Indexes past the list are ignored.
// Dataflow
//   The front end divides all features in parallel, two quotient bits per
//   cycle, and takes a new sample once the last result goes into the queue;
//   while the queue is full it holds that result. The back end takes a new
//   vector only after issuing every cluster of the last, and is fed through
//   a two-entry queue, so it never sets the rate.
// Reset
//   Synchronous, active low: clears the queue and all control state, zeroes
//   the ranges and centroids and loads the identity health map.
// ----------------------------------------------------------------------------
module nearest_centroid_classifier #(
    parameter int FEATURES = 5,
    parameter int CLUSTERS = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  ncc_pkg::t_code                    i_rpm_code,
    input  ncc_pkg::t_code                    i_temperature_code,
    input  ncc_pkg::t_code                    i_vibration_code,
    input  ncc_pkg::t_code                    i_current_code,
    input  ncc_pkg::t_code                    i_quality_code,
    input  logic                              i_cfg_we,
    input  logic [ncc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  ncc_pkg::t_word                    i_cfg_data,
    output logic                              o_done,
    output logic [ncc_pkg::IDX_W-1:0]         o_cluster_index,
    output logic [ncc_pkg::CLASS_W-1:0]       o_health_class,
    output ncc_pkg::t_dist                    o_nearest_distance
);
    import ncc_pkg::*;

    localparam t_map MAP_RESET = 6'd36;

    t_word     r_lows;
    t_word     r_highs;
    t_word [CLUSTERS-1:0] r_cen;
    t_map      r_map;

    logic      accept;
    t_feat_vec codes;
    logic      norm_valid;
    t_feat_vec norm_feat;
    logic      q_push;
    logic      q_pop;
    t_feat_vec q_data;
    t_q_status q_status;

    // Range and health map registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lows  <= '0;
            r_highs <= '0;
            r_map   <= MAP_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LOWS:  r_lows  <= i_cfg_data;
                CFG_HIGHS: r_highs <= i_cfg_data;
                CFG_MAP:   r_map   <= i_cfg_data[MAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Centroid registers, one per cluster
    for (genvar c = 0; c < CLUSTERS; c++) begin : g_cen
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cen[c] <= '0;
            end else if (i_cfg_we &&
                         (i_cfg_index == CFG_IDX_W'(int'(CFG_CEN0) + c))) begin
                r_cen[c] <= i_cfg_data;
            end
        end
    end

    assign codes[0] = i_rpm_code;
    assign codes[1] = i_temperature_code;
    assign codes[2] = i_vibration_code;
    assign codes[3] = i_current_code;
    assign codes[4] = i_quality_code;

    assign accept = start && !busy;
    assign q_push = norm_valid && !q_status.full;

    ncc_norm #(
        .FEATURES (FEATURES)
    ) u_norm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_codes   (codes),
        .i_lows    (r_lows),
        .i_highs   (r_highs),
        .i_push_ok (!q_status.full),
        .o_busy    (busy),
        .o_valid   (norm_valid),
        .o_feat    (norm_feat)
    );

    ncc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (norm_feat),
        .i_pop    (q_pop),
        .o_data   (q_data),
        .o_status (q_status)
    );

    ncc_dist #(
        .FEATURES (FEATURES),
        .CLUSTERS (CLUSTERS)
    ) u_dist (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_status         (q_status),
        .i_feat             (q_data),
        .i_cen              (r_cen),
        .i_map              (r_map),
        .o_pop              (q_pop),
        .o_done             (o_done),
        .o_cluster_index    (o_cluster_index),
        .o_health_class     (o_health_class),
        .o_nearest_distance (o_nearest_distance)
    );

    // The winner is always one of the configured clusters
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_cluster_index <= IDX_W'(CLUSTERS - 1)))
        else $error("cluster index out of range");

    // The back end pops only while no vector is being issued, so strobes never touch
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobes on consecutive cycles");

    // A taken sample keeps the front end occupied while it divides
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("front end free right after taking a sample");

endmodule
